FILE: design/mcma_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel moving average package
// Shared sizes, word formats and helper types for the moving average block.
// ----------------------------------------------------------------------------
package mcma_pkg;

  // Block configuration.
  localparam int CHANNELS    = 12;
  localparam int WIN_LOG2    = 5;
  localparam int WINDOW_DEPTH = 2 ** WIN_LOG2;
  localparam int SAMPLE_BITS = 12;

  // Port field widths.
  localparam int CHAN_W = 4;
  localparam int SAMP_W = 12;
  localparam int AVG_W  = 12;

  // Derived internal widths.
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W     = WIN_LOG2;
  localparam int ADDR_W     = CH_IDX_W + SLOT_W;
  localparam int RING_DEPTH = CHANNELS * WINDOW_DEPTH;
  localparam int SUM_W      = SAMPLE_BITS + WIN_LOG2;

  // Depth of the work queue and of the result buffer.
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 2;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [SAMP_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [AVG_W-1:0]  average;
  } out_word_t;

  // One classified sample on its way from the front end to the back end.
  typedef struct packed {
    logic [CH_IDX_W-1:0]    ch;
    logic [SLOT_W-1:0]      slot;
    logic [SAMPLE_BITS-1:0] sample;
  } work_t;

endpackage

FILE: design/mcma_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one word of a given packed type.
// ----------------------------------------------------------------------------
interface mcma_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mcma_front.sv
// ----------------------------------------------------------------------------
// Moving average front end
// Accepts samples, drops out-of-range channels, tags each sample with the
// shared write slot and queues it for the back end.
// ----------------------------------------------------------------------------
module mcma_front import mcma_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mcma_stream_if.sink   in_i,
  input  logic          clear_done_i,
  output logic          work_valid_o,
  output work_t         work_o,
  input  logic          work_pop_i
);

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  work_t             queue_q [QUEUE_DEPTH];

  logic   accept;
  logic   in_range;
  logic   push;
  work_t  entry;

  assign in_i.ready = clear_done_i && (count_q != QCNT_W'(QUEUE_DEPTH));
  assign accept     = in_i.valid && in_i.ready;
  assign in_range   = 32'(in_i.data.channel) < CHANNELS;
  assign push       = accept && in_range;

  always_comb begin
    entry.ch     = in_i.data.channel[CH_IDX_W-1:0];
    entry.slot   = slot_q;
    entry.sample = in_i.data.sample[SAMPLE_BITS-1:0];
  end

  // Only the last channel of a scan moves the ring position on.
  always_comb begin
    slot_d = slot_q;
    if (push && (32'(in_i.data.channel) == CHANNELS - 1)) begin
      if (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) begin
        slot_d = '0;
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (push && !work_pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push && work_pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      slot_q  <= slot_d;
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (work_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= entry;
    end
  end

  assign work_valid_o = (count_q != '0);
  assign work_o       = queue_q[rd_ptr_q];

  // The back end must never pop an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_pop_i |-> work_valid_o)
    else $error("work queue popped while empty");

  // A dropped channel leaves the ring position untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_range) |=> $stable(slot_q))
    else $error("write slot moved on a dropped sample");

endmodule

FILE: design/mcma_back.sv
// ----------------------------------------------------------------------------
// Moving average back end
// Holds the sample ring and channel sums, clears the ring after reset,
// updates the running sum and buffers the averages for the output.
// ----------------------------------------------------------------------------
module mcma_back import mcma_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          work_valid_i,
  input  work_t         work_i,
  output logic          work_pop_o,
  output logic          clear_done_o,
  mcma_stream_if.source out_o
);

  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  // Sample ring, one row of WINDOW_DEPTH entries per channel.
  logic [SAMPLE_BITS-1:0] ring_q [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] old_q;

  logic [ADDR_W-1:0] clr_addr_q;
  logic              clear_done_q;

  logic [SUM_W-1:0]  sums_q [CHANNELS];

  logic              s1_valid_q;
  work_t             s1_work_q;

  out_word_t         obuf_q [OUT_DEPTH];
  logic [OPTR_W-1:0] owr_ptr_q, ord_ptr_q;
  logic [OCNT_W-1:0] ocount_q, ocount_d;

  logic              issue;
  logic              out_pop;
  logic [OCNT_W:0]   committed;
  logic              ring_we;
  logic [ADDR_W-1:0] ring_addr;
  logic [SAMPLE_BITS-1:0] ring_wdata;
  logic [SUM_W-1:0]  new_sum;
  out_word_t         result;

  assign out_pop   = out_o.valid && out_o.ready;

  // Issue only when the result buffer is sure to have room once the read
  // returns, counting the item already in flight.
  assign committed = (OCNT_W + 1)'(ocount_q) + (OCNT_W + 1)'(s1_valid_q)
                   - (OCNT_W + 1)'(out_pop);
  assign issue      = work_valid_i && clear_done_q && (committed < (OCNT_W + 1)'(OUT_DEPTH));
  assign work_pop_o = issue;

  always_comb begin
    if (!clear_done_q) begin
      ring_we    = 1'b1;
      ring_addr  = clr_addr_q;
      ring_wdata = '0;
    end else begin
      ring_we    = issue;
      ring_addr  = {work_i.ch, work_i.slot};
      ring_wdata = work_i.sample;
    end
  end

  // Single port, read-first: the old entry comes out as the new one goes in.
  always_ff @(posedge clk_i) begin
    old_q <= ring_q[ring_addr];
    if (ring_we) begin
      ring_q[ring_addr] <= ring_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q   <= '0;
      clear_done_q <= 1'b0;
    end else if (!clear_done_q) begin
      if (clr_addr_q == ADDR_W'(RING_DEPTH - 1)) begin
        clear_done_q <= 1'b1;
      end else begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
    end
  end

  assign clear_done_o = clear_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_work_q <= work_i;
    end
  end

  assign new_sum = sums_q[s1_work_q.ch] - SUM_W'(old_q) + SUM_W'(s1_work_q.sample);

  always_comb begin
    result.out_channel = CHAN_W'(s1_work_q.ch);
    result.average     = AVG_W'(new_sum >> WIN_LOG2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sums_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      sums_q[s1_work_q.ch] <= new_sum;
    end
  end

  // Result buffer.
  always_comb begin
    ocount_d = ocount_q;
    if (s1_valid_q && !out_pop) begin
      ocount_d = ocount_q + OCNT_W'(1);
    end else if (!s1_valid_q && out_pop) begin
      ocount_d = ocount_q - OCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocount_q  <= '0;
      owr_ptr_q <= '0;
      ord_ptr_q <= '0;
    end else begin
      ocount_q <= ocount_d;
      if (s1_valid_q) begin
        owr_ptr_q <= (owr_ptr_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : owr_ptr_q + OPTR_W'(1);
      end
      if (out_pop) begin
        ord_ptr_q <= (ord_ptr_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ord_ptr_q + OPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      obuf_q[owr_ptr_q] <= result;
    end
  end

  assign out_o.valid = (ocount_q != '0);
  assign out_o.data  = obuf_q[ord_ptr_q];

  // A returning read always finds a free slot in the result buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ((ocount_q != OCNT_W'(OUT_DEPTH)) || out_pop))
    else $error("result buffer overflow");

  // The clearing pass runs once after reset and never restarts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(clear_done_q))
    else $error("ring clear restarted");

  // No sample reaches the ring before the clearing pass is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(clear_done_q))
    else $error("sample issued during ring clear");

endmodule

FILE: design/multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// Multichannel moving average
// Boxcar average over the last WINDOW_DEPTH samples of each channel.
// ----------------------------------------------------------------------------
//  Port    Dir  Word        Fields
//  in_i    in   in_word_t   channel[3:0], sample[11:0]
//  out_o   out  out_word_t  out_channel[3:0], average[11:0]
//
// One sample per cycle is taken while in_i.ready is high; each in-range
// sample gives one average after passing the work queue, the registered
// read of the sample ring and the result buffer.
// Samples of out-of-range channels are taken and dropped.
// After reset all RING_DEPTH (384) ring entries are cleared, one a cycle,
// with in_i.ready low. A two-word queue and a two-word result buffer let
// each side stall without holding up the other.
// ----------------------------------------------------------------------------
module multichannel_moving_average import mcma_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mcma_stream_if.sink   in_i,
  mcma_stream_if.source out_o
);

  logic  work_valid;
  logic  work_pop;
  logic  clear_done;
  work_t work;

  mcma_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .clear_done_i (clear_done),
    .work_valid_o (work_valid),
    .work_o       (work),
    .work_pop_i   (work_pop)
  );

  mcma_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_i       (work),
    .work_pop_o   (work_pop),
    .clear_done_o (clear_done),
    .out_o        (out_o)
  );

endmodule

FILE: test/mcma_checker.sv
// ----------------------------------------------------------------------------
// Moving average checker
// Watches the sample and average streams of the multichannel moving average,
// keeps its own copy of the per-channel windows and sums, and compares every
// average word against the value predicted for the sample that caused it.
// ----------------------------------------------------------------------------
module mcma_checker import mcma_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SAMPLE_BITS-1:0] window_q [CHANNELS][WINDOW_DEPTH];
  logic [SUM_W-1:0]       total_q  [CHANNELS];
  logic [SLOT_W-1:0]      slot_q;
  out_word_t              avg_queue [$];
  int                     fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [CH_IDX_W-1:0]    ch;
    logic [SAMPLE_BITS-1:0] smp;
    logic [SAMPLE_BITS-1:0] old;
    logic [SUM_W-1:0]       total;
    out_word_t              exp_w;
    out_word_t              got_w;
    int                     next_slot;
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        total_q[c] = '0;
        for (int d = 0; d < WINDOW_DEPTH; d++) window_q[c][d] = '0;
      end
      slot_q = '0;
      avg_queue.delete();
      pending_o <= 0;
      fail_count_o <= fails;
    end else begin
      // Averages leave only after their sample has passed the work queue, the ring read
      // and the result buffer, so the output side can be handled before the input side of this edge.
      if (out_valid_i && out_ready_i) begin
        got_w = out_data_i;
        if (avg_queue.size() == 0) begin
          fails++;
          $display("%0t: unexpected average word: expected none, actual channel %0d average %0d",
                   $time, got_w.out_channel, got_w.average);
        end else begin
          exp_w = avg_queue.pop_front();
          if (got_w.out_channel !== exp_w.out_channel) begin
            fails++;
            $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                     $time, exp_w.out_channel, got_w.out_channel);
          end
          if (got_w.average !== exp_w.average) begin
            fails++;
            $display("%0t: average mismatch on channel %0d: expected %0d, actual %0d",
                     $time, exp_w.out_channel, exp_w.average, got_w.average);
          end
        end
      end

      // Samples of channels beyond the last one are dropped without effect.
      if (in_valid_i && in_ready_i && in_data_i.channel < CHANNELS) begin
        ch    = in_data_i.channel[CH_IDX_W-1:0];
        smp   = in_data_i.sample[SAMPLE_BITS-1:0];
        old   = window_q[ch][slot_q];
        total = total_q[ch] - SUM_W'(old) + SUM_W'(smp);
        window_q[ch][slot_q] = smp;
        total_q[ch] = total;
        exp_w.out_channel = in_data_i.channel;
        exp_w.average     = AVG_W'(total / WINDOW_DEPTH);
        avg_queue.push_back(exp_w);
        if (ch == CHANNELS - 1) begin
          next_slot = int'(slot_q) + 1;
          slot_q = (next_slot >= WINDOW_DEPTH) ? '0 : SLOT_W'(next_slot);
        end
      end
      pending_o    <= avg_queue.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: test/multichannel_moving_average_tb.sv
// ----------------------------------------------------------------------------
// Multichannel moving average testbench
// Drives directed and random sample scans with random stalls on both streams
// into the moving average block, lets the checker predict and compare every
// average word, and reports the verdict once all averages have drained or a wait limit runs out.
// ----------------------------------------------------------------------------
module multichannel_moving_average_tb;
  import mcma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_TARGET = 1250;
  localparam int CALM_AFTER    = 1150;
  localparam int MAX_SCANS     = 34;

  logic clk_i;
  logic rst_ni;
  logic calm;
  int   sent_cnt;
  int   fail_count;
  int   pending;

  mcma_stream_if #(.word_t(in_word_t))  in_if ();
  mcma_stream_if #(.word_t(out_word_t)) out_if ();

  multichannel_moving_average dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mcma_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  // Offers one sample word and returns at the falling edge after it is taken.
  task automatic send_word(input logic [CHAN_W-1:0] ch, input logic [SAMP_W-1:0] smp);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {ch, smp};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (ch < CHANNELS) sent_cnt++;
    @(negedge clk_i);
  endtask

  function automatic logic [SAMP_W-1:0] pick_sample(input int flavor);
    case (flavor)
      1: pick_sample = '1;
      2: pick_sample = '0;
      3: pick_sample = SAMP_W'($urandom_range(0, 3));
      4: pick_sample = SAMP_W'(4095 - $urandom_range(0, 3));
      default: pick_sample = SAMP_W'($urandom);
    endcase
  endfunction

  // Result side: random stall bursts, steady ready once the run calms down.
  initial begin : sink_side
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        out_if.ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 8);
        out_if.ready <= 1'b1;
      end
      repeat (n - 1) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int scan_idx;
    int mode;
    int flavor;
    int n;
    int waited;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    calm        = 1'b0;
    sent_cnt    = 0;
    rst_ni      = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one scan of extreme samples, dropped channels, a channel
    // written twice before the slot moves, and an out-of-order advance.
    for (int c = 0; c < CHANNELS; c++) begin
      case (c % 4)
        0: send_word(CHAN_W'(c), 12'hFFF);
        1: send_word(CHAN_W'(c), 12'h000);
        2: send_word(CHAN_W'(c), 12'h001);
        default: send_word(CHAN_W'(c), 12'h800);
      endcase
    end
    send_word(4'd12, 12'hFFF);
    send_word(4'd15, 12'hAAA);
    send_word(4'd5, 12'hFFF);
    send_word(4'd5, 12'h007);
    send_word(4'd0, 12'hFFF);
    send_word(4'd11, 12'hFFF);
    send_word(4'd3, 12'h555);
    send_word(4'd11, 12'h000);
    send_word(4'd14, 12'h000);

    // Random: first fill every window with full-scale samples, then mix
    // clean scans of varied content with shuffled scans and raw noise.
    scan_idx = 0;
    while (sent_cnt < SAMPLE_TARGET) begin
      if (sent_cnt >= CALM_AFTER) calm = 1'b1;
      mode   = (scan_idx < MAX_SCANS) ? 9 : $urandom_range(0, 9);
      flavor = (scan_idx < MAX_SCANS) ? 1 : $urandom_range(0, 4);
      if (mode == 0) begin
        n = $urandom_range(1, 12);
        repeat (n) send_word(CHAN_W'($urandom_range(0, 15)), SAMP_W'($urandom));
      end else if (mode == 1) begin
        n = $urandom_range(1, 14);
        repeat (n) send_word(CHAN_W'($urandom_range(0, CHANNELS - 1)), pick_sample(flavor));
      end else begin
        for (int c = 0; c < CHANNELS; c++) send_word(CHAN_W'(c), pick_sample(flavor));
      end
      scan_idx++;
    end
    in_if.valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (16) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mcma_pkg.sv
design/mcma_stream_if.sv
design/mcma_front.sv
design/mcma_back.sv
design/multichannel_moving_average.sv
test/mcma_checker.sv
test/multichannel_moving_average_tb.sv
